@@ design/isa_pkg.sv @@
// Package for the interval slot allocator: sizes, field widths, helpers.
// No dependencies; used by the top level.
`default_nettype none
package isa_pkg;
  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ELEM_BYTES = 8;
  localparam int CAP_W     = 20;
  localparam int LU_W      = 11;
  localparam int RANK_W    = 10;
  localparam int BYTE_W    = 24;
  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};
  localparam logic [3:0] MIN_LOG2 = 4'd5;
  localparam logic [3:0] MAX_LOG2 = 4'd12;

  localparam logic [1:0] REG_ALIGN = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_REUSE = 2'd2;

  localparam logic CMD_PLACE  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  function automatic logic [3:0] eff_log2(input logic [3:0] lg);
    logic [3:0] r;
    r = lg;
    if (lg < MIN_LOG2) r = MIN_LOG2;
    if (lg > MAX_LOG2) r = MAX_LOG2;
    return r;
  endfunction

  // Round up to alignment and saturate to the byte range.
  function automatic logic [BYTE_W-1:0] align_up(input logic [BYTE_W:0] v,
                                                 input logic [3:0] lg);
    logic [BYTE_W+1:0] m;
    logic [BYTE_W+1:0] r;
    m = (({{(BYTE_W+1){1'b0}}, 1'b1}) << eff_log2(lg)) - 1'b1;
    r = ({1'b0, v} + m) & ~m;
    return (r > {2'b00, BYTE_MAX}) ? BYTE_MAX : r[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W] ? BYTE_MAX : s[BYTE_W-1:0];
  endfunction
endpackage
`default_nettype wire

@@ design/isa_in_if.sv @@
// Input channel: valid/ready handshake with one allocation request beat.
// Standalone interface.
`default_nettype none
interface isa_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [9:0]  buffer_tag;
  logic [9:0]  live_start;
  logic [10:0] live_end;
  logic [15:0] entry_count;
  modport source (output valid, cmd, buffer_tag, live_start, live_end, entry_count,
                  input ready);
  modport sink   (input valid, cmd, buffer_tag, live_start, live_end, entry_count,
                  output ready);
endinterface
`default_nettype wire

@@ design/isa_out_if.sv @@
// Result channel: valid/ready handshake with one placement or listing beat.
// Standalone interface.
`default_nettype none
interface isa_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  tag_out;
  logic        pool_select;
  logic [3:0]  slot_number;
  logic [23:0] byte_offset;
  logic [23:0] byte_size;
  logic [23:0] stack_extent;
  logic [23:0] arena_extent;
  logic [4:0]  stack_slot_total;
  logic [4:0]  arena_slot_total;
  logic        status;
  logic        last;
  modport source (output valid, tag_out, pool_select, slot_number, byte_offset,
                  byte_size, stack_extent, arena_extent, stack_slot_total,
                  arena_slot_total, status, last, input ready);
  modport sink   (input valid, tag_out, pool_select, slot_number, byte_offset,
                  byte_size, stack_extent, arena_extent, stack_slot_total,
                  arena_slot_total, status, last, output ready);
endinterface
`default_nettype wire

@@ design/interval_slot_allocator_top.sv @@
// Interval slot allocator: one sequencer with a shared compare unit that walks
// the slot table once for expiry and once for best fit. Uses isa_pkg, isa_in_if, isa_out_if.
// Placement: walk the chosen pool's used slots (up to 16) once for expiry, then for best fit,
// then commit and hold the result beat until it is taken; only then is the next item accepted.
// Finish: one listing beat per stack slot, then a summary beat; both pools are emptied when
// the summary beat is taken. One item at a time; the table walk covers one slot per cycle.
// Synchronous active-low reset clears config to defaults and empties both pools.
`default_nettype none
module interval_slot_allocator_top
  import isa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  isa_in_if.sink           in_ch,
  isa_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_EXPIRE, S_FIT, S_COMMIT, S_PLACE_OUT, S_LIST, S_LIST_OUT, S_SUM_OUT
  } state_t;

  state_t state_r;
  logic [3:0]  align_r;
  logic [15:0] limit_r;
  logic        reuse_r;

  logic [CAP_W-1:0]  cap_r   [2][SLOTS];
  logic [LU_W-1:0]   lu_r    [2][SLOTS];
  logic [RANK_W-1:0] rank_r  [2][SLOTS];
  logic [BYTE_W-1:0] aoff_r  [SLOTS];
  logic [SLOTS-1:0]  free_r  [2];
  logic [CNT_W-1:0]  used_r  [2];
  logic [BYTE_W-1:0] cursor_r;
  logic [RANK_W-1:0] seq_r;

  logic              pool_r;
  logic [9:0]        tag_r;
  logic [9:0]        start_r;
  logic [10:0]       end_r;
  logic [CAP_W-1:0]  bytes_r;
  logic [CNT_W-1:0]  idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] best_r;
  logic [CAP_W-1:0]  fit_cap_r;
  logic [RANK_W-1:0] best_age_r;
  logic [LU_W-1:0]   best_lu_r;
  logic [BYTE_W-1:0] best_off_r;
  logic [BYTE_W-1:0] list_cur_r;

  logic              out_valid_r;
  logic [9:0]        o_tag_r;
  logic              o_pool_r;
  logic [3:0]        o_slot_r;
  logic [23:0]       o_off_r, o_size_r, o_st_r, o_at_r;
  logic [4:0]        o_scnt_r, o_acnt_r;
  logic              o_status_r, o_last_r;

  logic              cfg_wr;
  logic [SLOT_W-1:0] ix;
  logic [CAP_W-1:0]  cur_cap;
  logic [RANK_W-1:0] cur_age;
  logic              fit_hit;
  logic [18:0]       raw_bytes;
  logic [BYTE_W-1:0] in_bytes;
  logic [BYTE_W-1:0] new_off;
  logic [BYTE_W-1:0] list_off;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ALIGN: cfg_prdata = {28'd0, align_r};
      REG_LIMIT: cfg_prdata = {16'd0, limit_r};
      REG_REUSE: cfg_prdata = {31'd0, reuse_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  assign ix       = idx_r[SLOT_W-1:0];
  assign cur_cap  = cap_r[pool_r][ix];
  assign cur_age  = seq_r - rank_r[pool_r][ix];
  assign fit_hit  = free_r[pool_r][ix] && (cur_cap >= bytes_r) &&
                    (!found_r || cur_cap < fit_cap_r ||
                     (cur_cap == fit_cap_r && cur_age > best_age_r));
  assign raw_bytes = 19'(in_ch.entry_count * ELEM_BYTES);
  assign in_bytes = align_up({6'd0, raw_bytes}, align_r);
  assign new_off  = align_up({1'b0, cursor_r}, align_r);
  assign list_off = align_up({1'b0, list_cur_r}, align_r);

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.tag_out          = o_tag_r;
  assign out_ch.pool_select      = o_pool_r;
  assign out_ch.slot_number      = o_slot_r;
  assign out_ch.byte_offset      = o_off_r;
  assign out_ch.byte_size        = o_size_r;
  assign out_ch.stack_extent     = o_st_r;
  assign out_ch.arena_extent     = o_at_r;
  assign out_ch.stack_slot_total = o_scnt_r;
  assign out_ch.arena_slot_total = o_acnt_r;
  assign out_ch.status           = o_status_r;
  assign out_ch.last             = o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      align_r     <= 4'd5;
      limit_r     <= 16'd64;
      reuse_r     <= 1'b1;
      free_r[0]   <= '0;
      free_r[1]   <= '0;
      used_r[0]   <= '0;
      used_r[1]   <= '0;
      cursor_r    <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_ALIGN: align_r <= cfg_pwdata[3:0];
          REG_LIMIT: limit_r <= cfg_pwdata[15:0];
          REG_REUSE: reuse_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            tag_r      <= in_ch.buffer_tag;
            start_r    <= in_ch.live_start;
            end_r      <= in_ch.live_end;
            bytes_r    <= in_bytes[CAP_W-1:0];
            pool_r     <= !(in_ch.entry_count <= limit_r);
            idx_r      <= '0;
            found_r    <= 1'b0;
            list_cur_r <= '0;
            state_r    <= (in_ch.cmd == CMD_FINISH) ? S_LIST : S_EXPIRE;
          end
        end
        S_EXPIRE: begin
          if (idx_r < used_r[pool_r]) begin
            if (!free_r[pool_r][ix] && lu_r[pool_r][ix] < {1'b0, start_r}) begin
              free_r[pool_r][ix] <= 1'b1;
              rank_r[pool_r][ix] <= seq_r;
              seq_r              <= seq_r + 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end else begin
            idx_r   <= '0;
            state_r <= S_FIT;
          end
        end
        S_FIT: begin
          if (idx_r < used_r[pool_r]) begin
            if (fit_hit) begin
              found_r    <= 1'b1;
              best_r     <= ix;
              fit_cap_r  <= cur_cap;
              best_age_r <= cur_age;
              best_lu_r  <= lu_r[pool_r][ix];
              best_off_r <= aoff_r[ix];
            end
            idx_r <= idx_r + 1'b1;
          end else begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          o_tag_r    <= tag_r;
          o_pool_r   <= pool_r;
          o_size_r   <= {4'd0, bytes_r};
          o_st_r     <= '0;
          o_at_r     <= '0;
          o_last_r   <= 1'b1;
          if (found_r && reuse_r) begin
            free_r[pool_r][best_r] <= 1'b0;
            if (end_r > best_lu_r) lu_r[pool_r][best_r] <= end_r;
            o_slot_r   <= best_r;
            o_off_r    <= pool_r ? best_off_r : '0;
            o_scnt_r   <= used_r[0];
            o_acnt_r   <= used_r[1];
            o_status_r <= 1'b0;
          end else if (used_r[pool_r] < CNT_W'(SLOTS)) begin
            cap_r[pool_r][used_r[pool_r][SLOT_W-1:0]]  <= bytes_r;
            lu_r[pool_r][used_r[pool_r][SLOT_W-1:0]]   <= end_r;
            free_r[pool_r][used_r[pool_r][SLOT_W-1:0]] <= 1'b0;
            used_r[pool_r] <= used_r[pool_r] + 1'b1;
            if (pool_r) begin
              aoff_r[used_r[1][SLOT_W-1:0]] <= new_off;
              cursor_r <= sat_add(new_off, {4'd0, bytes_r});
              o_scnt_r <= used_r[0];
              o_acnt_r <= used_r[1] + 1'b1;
            end else begin
              o_scnt_r <= used_r[0] + 1'b1;
              o_acnt_r <= used_r[1];
            end
            o_slot_r   <= used_r[pool_r][SLOT_W-1:0];
            o_off_r    <= pool_r ? new_off : '0;
            o_status_r <= 1'b0;
          end else begin
            o_slot_r   <= '0;
            o_off_r    <= '0;
            o_scnt_r   <= used_r[0];
            o_acnt_r   <= used_r[1];
            o_status_r <= 1'b1;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_PLACE_OUT;
        end
        S_PLACE_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_LIST: begin
          o_tag_r    <= '0;
          o_pool_r   <= 1'b0;
          o_status_r <= 1'b0;
          o_scnt_r   <= used_r[0];
          o_acnt_r   <= used_r[1];
          out_valid_r <= 1'b1;
          if (idx_r < used_r[0]) begin
            o_slot_r   <= ix;
            o_off_r    <= list_off;
            o_size_r   <= {4'd0, cap_r[0][ix]};
            o_st_r     <= '0;
            o_at_r     <= '0;
            o_last_r   <= 1'b0;
            list_cur_r <= sat_add(list_off, {4'd0, cap_r[0][ix]});
            idx_r      <= idx_r + 1'b1;
            state_r    <= S_LIST_OUT;
          end else begin
            o_slot_r <= '0;
            o_off_r  <= '0;
            o_size_r <= '0;
            o_st_r   <= list_off;
            o_at_r   <= new_off;
            o_last_r <= 1'b1;
            state_r  <= S_SUM_OUT;
          end
        end
        S_LIST_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_LIST;
          end
        end
        S_SUM_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            free_r[0]   <= '0;
            free_r[1]   <= '0;
            used_r[0]   <= '0;
            used_r[1]   <= '0;
            cursor_r    <= '0;
            seq_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
